// File: hdl/stup_pkg.sv
// ----------------------------------------------------------------------------
// stup_pkg
// Shared types and character constants for the string to unsigned parser.
// ----------------------------------------------------------------------------
package stup_pkg;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7a;  // 'z'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // base limits
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  // digit code for a character that is no digit in any base
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BADBASE  = 2'd2;

  // field widths of the result
  localparam int OUT_VALUE_W  = 32;
  localparam int OUT_OFFSET_W = 12;

  // register byte address bit for register index
  localparam logic REG_BASE_SELECT = 1'b0;

  // classified character as it travels through the queue
  typedef struct packed {
    logic       first;
    logic [5:0] base;
    logic [5:0] digit;
    logic       is_space;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
  } q_item_t;

endpackage

// File: hdl/string_to_unsigned_parser_top.sv
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_top
// Character-stream unsigned integer parser with an APB base register.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while no held result stalls
// it, and gives one result per string on the cycle that the first non-digit
// character is parsed. A result reaches the output through the two-entry
// input queue, where its stopping character waits, and is parsed straight
// into the output register. A result held by out_stall blocks further
// parsing, and the input stalls once the queue holds two items. The rate is
// set by the parser step, which does one multiply-add of the accumulator by
// the base per character. base_select is sampled with the item that has
// first set, so writes between strings take effect on the next string. A
// first character arriving mid-string drops the string in progress.
module string_to_unsigned_parser_top
  import stup_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_OFFSET = 4095
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input characters
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_ch,
  input  logic                    in_first,
  // results
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_VALUE_W-1:0]  out_value,
  output logic [OUT_OFFSET_W-1:0] out_end_offset,
  output logic [1:0]              out_status,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [OUT_VALUE_W-1:0] OUT_OVF_VALUE =
    OUT_VALUE_W'({VALUE_BITS{1'b1}});

  logic [5:0] base_select_r;
  q_item_t    front_item;
  q_item_t    head_item;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;
  logic       in_take;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASE_SELECT) ? {26'b0, base_select_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_select_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BASE_SELECT) begin
      base_select_r <= pwdata[5:0];
    end
  end

  // input handshake
  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  stup_front u_front (
    .in_ch    (in_ch),
    .in_first (in_first),
    .base_sel (base_select_r),
    .item     (front_item)
  );

  stup_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_take),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (head_item)
  );

  stup_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_OFFSET (MAX_OFFSET)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_item      (head_item),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_status     (out_status)
  );

  // invalid base reports a zero value at offset zero
  a_badbase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BADBASE |-> out_value == '0 && out_end_offset == '0)
    else $error("invalid base result carries data");

  // overflow always saturates the value
  a_ovf_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> out_value == OUT_OVF_VALUE)
    else $error("overflow result not saturated");

  // no reserved status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_OVERFLOW ||
                  out_status == ST_BADBASE)
    else $error("reserved status code");

  // the parser never consumes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("pop from empty queue");

endmodule

// File: hdl/stup_front.sv
// ----------------------------------------------------------------------------
// stup_front
// Classifies each incoming character: digit value, whitespace, sign, prefix
// characters, and tags it with the base in force when the item is accepted.
// ----------------------------------------------------------------------------
module stup_front
  import stup_pkg::*;
(
  input  logic [7:0] in_ch,
  input  logic       in_first,
  input  logic [5:0] base_sel,
  output q_item_t    item
);

  logic [5:0] digit;

  // digit value in 0..35, or no digit
  always_comb begin
    if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
      digit = 6'(in_ch - CH_ZERO);
    end else if (in_ch >= CH_LA && in_ch <= CH_LZ) begin
      digit = 6'(in_ch - CH_LA) + BASE_DEC;
    end else if (in_ch >= CH_UA && in_ch <= CH_UZ) begin
      digit = 6'(in_ch - CH_UA) + BASE_DEC;
    end else begin
      digit = DIGIT_NONE;
    end
  end

  // pack the classified item
  always_comb begin
    item.first    = in_first;
    item.base     = base_sel;
    item.digit    = digit;
    item.is_space = (in_ch == CH_SPACE) || (in_ch >= CH_TAB && in_ch <= CH_CR);
    item.is_plus  = (in_ch == CH_PLUS);
    item.is_zero  = (in_ch == CH_ZERO);
    item.is_x     = (in_ch == CH_LX) || (in_ch == CH_UX);
  end

endmodule

// File: hdl/stup_queue.sv
// ----------------------------------------------------------------------------
// stup_queue
// Two-entry queue of classified items between the front and the parser.
// ----------------------------------------------------------------------------
module stup_queue
  import stup_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head_item
);

  q_item_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/stup_back.sv
// ----------------------------------------------------------------------------
// stup_back
// Parser: walks the leading-space, sign, prefix and digit phases one item per
// cycle unless a held result stalls, accumulates digits, registers the result.
// ----------------------------------------------------------------------------
module stup_back
  import stup_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_OFFSET = 4095
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  q_item_t                 head_item,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_VALUE_W-1:0]  out_value,
  output logic [OUT_OFFSET_W-1:0] out_end_offset,
  output logic [1:0]              out_status
);

  localparam int CNT_W  = $clog2(MAX_OFFSET + 1);
  localparam int PROD_W = VALUE_BITS + 6;
  localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_OFFSET);
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_LEAD    = 6'b000010,
    PH_PREFIX  = 6'b000100,
    PH_ZERO    = 6'b001000,
    PH_AFTER_X = 6'b010000,
    PH_DIGITS  = 6'b100000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [5:0]              base_r, base_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    have_dig_r, have_dig_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    emit;
  logic [VALUE_BITS-1:0]   emit_value;
  logic [CNT_W-1:0]        emit_offset;
  logic [1:0]              emit_status;

  logic                    out_valid_r;
  logic [OUT_VALUE_W-1:0]  out_value_r;
  logic [OUT_OFFSET_W-1:0] out_offset_r;
  logic [1:0]              out_status_r;

  assign pop            = head_valid && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_end_offset = out_offset_r;
  assign out_status     = out_status_r;

  // one parse step for the item at the head of the queue
  always_comb begin
    logic             bump;
    logic             dstep;
    logic             pfx;
    logic [PROD_W-1:0] prod;

    phase_nxt    = phase_r;
    base_nxt     = base_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    have_dig_nxt = have_dig_r;
    ovf_nxt      = ovf_r;
    emit         = 1'b0;
    emit_value   = '0;
    emit_offset  = '0;
    emit_status  = ST_OK;
    bump         = 1'b0;
    dstep        = 1'b0;
    pfx          = 1'b0;
    prod         = '0;

    // new string: sample base and clear the accumulation
    if (head_item.first) begin
      acc_nxt      = '0;
      cnt_nxt      = '0;
      have_dig_nxt = 1'b0;
      ovf_nxt      = 1'b0;
      base_nxt     = head_item.base;
      if (head_item.base == BASE_ONE || head_item.base > BASE_MAX) begin
        emit        = 1'b1;
        emit_status = ST_BADBASE;
        phase_nxt   = PH_IDLE;
      end else begin
        phase_nxt = PH_LEAD;
      end
    end

    if (!emit) begin
      unique case (phase_nxt)
        PH_LEAD: begin
          if (head_item.is_space) begin
            bump = 1'b1;
          end else if (head_item.is_plus) begin
            phase_nxt = PH_PREFIX;
            bump      = 1'b1;
          end else begin
            pfx = 1'b1;
          end
        end
        PH_PREFIX: begin
          pfx = 1'b1;
        end
        PH_ZERO: begin
          if (head_item.is_x) begin
            phase_nxt = PH_AFTER_X;
            bump      = 1'b1;
          end else begin
            if (base_nxt == BASE_AUTO) begin
              base_nxt = BASE_OCT;
            end
            dstep = 1'b1;
          end
        end
        PH_AFTER_X: begin
          base_nxt = BASE_HEX;
          if (head_item.digit < BASE_HEX) begin
            dstep = 1'b1;
          end else begin
            emit        = 1'b1;
            emit_offset = (cnt_nxt != '0) ? cnt_nxt - CNT_W'(1) : '0;
            phase_nxt   = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          dstep = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // leading zero or first digit handling, shared by the lead and prefix phases
    if (pfx) begin
      if (head_item.is_zero && (base_nxt == BASE_AUTO || base_nxt == BASE_HEX)) begin
        phase_nxt    = PH_ZERO;
        have_dig_nxt = 1'b1;
        bump         = 1'b1;
      end else begin
        if (base_nxt == BASE_AUTO) begin
          base_nxt = BASE_DEC;
        end
        dstep = 1'b1;
      end
    end

    // digit accumulation or stop
    if (dstep) begin
      if (head_item.digit >= base_nxt) begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
        if (!have_dig_nxt) begin
          emit_value  = '0;
          emit_offset = '0;
          emit_status = ST_OK;
        end else if (ovf_nxt) begin
          emit_value  = VALUE_MAX;
          emit_offset = cnt_nxt;
          emit_status = ST_OVERFLOW;
        end else begin
          emit_value  = acc_nxt;
          emit_offset = cnt_nxt;
          emit_status = ST_OK;
        end
      end else begin
        prod = PROD_W'(acc_nxt) * PROD_W'(base_nxt) + PROD_W'(head_item.digit);
        if (!ovf_nxt) begin
          if (|prod[PROD_W-1:VALUE_BITS]) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[VALUE_BITS-1:0];
          end
        end
        have_dig_nxt = 1'b1;
        phase_nxt    = PH_DIGITS;
        bump         = 1'b1;
      end
    end

    // saturating character count
    if (bump && cnt_nxt < CNT_MAX) begin
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      base_r     <= '0;
      acc_r      <= '0;
      cnt_r      <= '0;
      have_dig_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else if (pop) begin
      phase_r    <= phase_nxt;
      base_r     <= base_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      have_dig_r <= have_dig_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // output register, holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_value_r  <= OUT_VALUE_W'(emit_value);
      out_offset_r <= OUT_OFFSET_W'(emit_offset);
      out_status_r <= emit_status;
    end
  end

endmodule
